// ===== hdl/gcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the gated capacitance meter.
// Used by every module of the block; depends on nothing.
package gcm_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int GATE_W      = 16;
	localparam int RES_W       = 20;
	localparam int NUM_W       = 32;
	localparam int DEN_W       = RES_W + COUNT_WIDTH;
	localparam int QUO_W       = NUM_W;
	localparam int STEP_W      = $clog2(QUO_W);
	localparam int REG_IDX_W   = 2;
	localparam int WDATA_W     = 32;

	localparam int GQ_DEPTH    = 2;
	localparam int GQ_PTR_W    = (GQ_DEPTH > 1) ? $clog2(GQ_DEPTH) : 1;
	localparam int GQ_CNT_W    = $clog2(GQ_DEPTH + 1);

	localparam logic [REG_IDX_W-1:0] REG_GATE_TICKS     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RESISTANCE_SUM = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CAP_NUMERATOR  = 2'd2;

	localparam logic [GATE_W-1:0] GATE_TICKS_RST     = 16'd1000;
	localparam logic [RES_W-1:0]  RESISTANCE_SUM_RST = 20'd4800;
	localparam logic [NUM_W-1:0]  CAP_NUMERATOR_RST  = 32'd1440000000;
	localparam logic [QUO_W-1:0]  NF_PER_UF          = 32'd1000;

	// x / 1000 == (x * 274877907) >> 38, exact for every 32-bit x
	localparam int                RECIP_W         = 29;
	localparam int                PROD_W          = QUO_W + RECIP_W;
	localparam int                NF_PER_UF_SHIFT = 38;
	localparam logic [RECIP_W-1:0] NF_PER_UF_RECIP = 29'd274877907;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] count;
	} gate_t;

	typedef struct packed {
		logic [31:0] frequency;
		logic        no_signal;
		logic [31:0] cap_value;
		logic        unit_is_uf;
	} res_t;

endpackage

// ===== hdl/gcm_front.sv =====
`timescale 1ns / 1ps
// Front part: edge and tick counters, gate-end detection.
// Depends on gcm_pkg.
module gcm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic                             signal_edge,
	input  logic                             base_tick,
	input  logic [gcm_pkg::GATE_W-1:0]       gate_ticks,
	output logic                             gate_valid,
	output gcm_pkg::gate_t                   gate
);

	logic [gcm_pkg::COUNT_WIDTH-1:0] edge_q;
	logic [gcm_pkg::GATE_W-1:0]      tick_q;
	logic [gcm_pkg::COUNT_WIDTH-1:0] edge_nx;
	logic [gcm_pkg::GATE_W-1:0]      tick_nx;
	logic                            close;

	always_comb begin
		edge_nx = edge_q;
		if (signal_edge && (edge_q != '1)) begin
			edge_nx = edge_q + 1'b1;
		end
		tick_nx = tick_q + 1'b1;
		close   = base_tick && ((tick_nx >= gate_ticks) || (tick_nx == '0));
	end

	assign gate_valid = accept && close;
	assign gate.count = edge_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= '0;
			tick_q <= '0;
		end else if (accept) begin
			if (close) begin
				edge_q <= '0;
				tick_q <= '0;
			end else begin
				edge_q <= edge_nx;
				if (base_tick) begin
					tick_q <= tick_nx;
				end
			end
		end
	end

endmodule

// ===== hdl/gcm_gate_queue.sv =====
`timescale 1ns / 1ps
// Short queue of closed gates between the front and back parts.
// Depends on gcm_pkg.
module gcm_gate_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  gcm_pkg::gate_t wr_data,
	input  logic           rd,
	output gcm_pkg::gate_t rd_data,
	output logic           q_full,
	output logic           q_empty
);

	gcm_pkg::gate_t                  mem_q [gcm_pkg::GQ_DEPTH];
	logic [gcm_pkg::GQ_PTR_W-1:0]    wr_ptr_q;
	logic [gcm_pkg::GQ_PTR_W-1:0]    rd_ptr_q;
	logic [gcm_pkg::GQ_CNT_W-1:0]    cnt_q;

	localparam logic [gcm_pkg::GQ_PTR_W-1:0] PTR_LAST = gcm_pkg::GQ_PTR_W'(gcm_pkg::GQ_DEPTH - 1);
	localparam logic [gcm_pkg::GQ_CNT_W-1:0] CNT_FULL = gcm_pkg::GQ_CNT_W'(gcm_pkg::GQ_DEPTH);

	assign q_full  = (cnt_q == CNT_FULL);
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/gcm_back.sv =====
`timescale 1ns / 1ps
// Back part: product, restoring divider, reciprocal unit scaling and result register.
// Depends on gcm_pkg.
module gcm_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  gcm_pkg::gate_t               q_data,
	output logic                         q_pop,
	input  logic [gcm_pkg::RES_W-1:0]    resistance_sum,
	input  logic [gcm_pkg::NUM_W-1:0]    cap_numerator,
	input  logic                         pop,
	output logic                         res_valid,
	output gcm_pkg::res_t                res
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_DIV   = 5'b00100,
		S_SCALE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                            state_q;
	logic [gcm_pkg::COUNT_WIDTH-1:0]   count_q;
	logic [gcm_pkg::DEN_W-1:0]         den_q;
	logic [gcm_pkg::DEN_W-1:0]         rem_q;
	logic [gcm_pkg::QUO_W-1:0]         quo_q;
	logic [gcm_pkg::STEP_W-1:0]        step_q;
	logic                              uf_q;
	logic                              res_valid_q;
	gcm_pkg::res_t                     res_q;

	logic [gcm_pkg::DEN_W:0]           trial;
	logic [gcm_pkg::DEN_W:0]           diff;
	logic                              take;
	logic [gcm_pkg::DEN_W-1:0]         rem_nx;
	logic [gcm_pkg::PROD_W-1:0]        uf_prod;

	localparam logic [gcm_pkg::STEP_W-1:0] STEP_LAST = gcm_pkg::STEP_W'(gcm_pkg::QUO_W - 1);

	always_comb begin
		trial   = {rem_q, quo_q[gcm_pkg::QUO_W-1]};
		diff    = trial - {1'b0, den_q};
		take    = (trial >= {1'b0, den_q});
		rem_nx  = take ? diff[gcm_pkg::DEN_W-1:0] : trial[gcm_pkg::DEN_W-1:0];
		uf_prod = gcm_pkg::PROD_W'(quo_q) * gcm_pkg::PROD_W'(gcm_pkg::NF_PER_UF_RECIP);
	end

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				count_q <= q_data.count;
			end
			S_MUL: begin
				den_q  <= gcm_pkg::DEN_W'(resistance_sum) * gcm_pkg::DEN_W'(count_q);
				rem_q  <= '0;
				quo_q  <= (count_q == '0) ? '0 : cap_numerator;
				step_q <= '0;
				uf_q   <= 1'b0;
			end
			S_DIV: begin
				rem_q  <= rem_nx;
				quo_q  <= {quo_q[gcm_pkg::QUO_W-2:0], take};
				step_q <= step_q + 1'b1;
			end
			S_SCALE: begin
				if (quo_q >= gcm_pkg::NF_PER_UF) begin
					quo_q <= gcm_pkg::QUO_W'(uf_prod[gcm_pkg::PROD_W-1:gcm_pkg::NF_PER_UF_SHIFT]);
					uf_q  <= 1'b1;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
		if ((state_q == S_DONE) && (!res_valid_q || pop)) begin
			res_q.frequency  <= 32'(count_q);
			res_q.no_signal  <= (count_q == '0);
			res_q.cap_value  <= quo_q;
			res_q.unit_is_uf <= uf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= (count_q == '0) ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (step_q == STEP_LAST) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || pop) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((state_q == S_DONE) && (!res_valid_q || pop)) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/gated_capacitance_meter_unit.sv =====
`timescale 1ns / 1ps
// Gated capacitance meter, top level: configuration registers, front, gate queue, back.
// A closed gate passes through the product, divider and scaling states; a gate that saw no edge skips the last two.
// Throughput: one input transaction per cycle while full is low; the back part takes one gate at a time
// (32-step divider), so full rises only when two closed gates wait in the queue.
// Reset: counters, queue and result valid flag clear; registers take their reset values.
module gated_capacitance_meter_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             signal_edge,
	input  logic                             base_tick,
	output logic                             empty,
	input  logic                             pop,
	output logic [31:0]                      frequency,
	output logic                             no_signal,
	output logic [31:0]                      cap_value,
	output logic                             unit_is_uf,
	input  logic                             wr_en,
	input  logic [gcm_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [gcm_pkg::WDATA_W-1:0]      wr_data
);

	logic [gcm_pkg::GATE_W-1:0] gate_ticks_q;
	logic [gcm_pkg::RES_W-1:0]  resistance_sum_q;
	logic [gcm_pkg::NUM_W-1:0]  cap_numerator_q;

	logic           accept;
	logic           gate_valid;
	gcm_pkg::gate_t gate;
	gcm_pkg::gate_t q_data;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	logic           res_valid;
	gcm_pkg::res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_ticks_q     <= gcm_pkg::GATE_TICKS_RST;
			resistance_sum_q <= gcm_pkg::RESISTANCE_SUM_RST;
			cap_numerator_q  <= gcm_pkg::CAP_NUMERATOR_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				gcm_pkg::REG_GATE_TICKS:     gate_ticks_q     <= wr_data[gcm_pkg::GATE_W-1:0];
				gcm_pkg::REG_RESISTANCE_SUM: resistance_sum_q <= wr_data[gcm_pkg::RES_W-1:0];
				gcm_pkg::REG_CAP_NUMERATOR:  cap_numerator_q  <= wr_data[gcm_pkg::NUM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	gcm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.signal_edge (signal_edge),
		.base_tick   (base_tick),
		.gate_ticks  (gate_ticks_q),
		.gate_valid  (gate_valid),
		.gate        (gate)
	);

	gcm_gate_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (gate_valid),
		.wr_data (gate),
		.rd      (q_pop),
		.rd_data (q_data),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	gcm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (q_data),
		.q_pop          (q_pop),
		.resistance_sum (resistance_sum_q),
		.cap_numerator  (cap_numerator_q),
		.pop            (pop),
		.res_valid      (res_valid),
		.res            (res)
	);

	assign empty      = !res_valid;
	assign frequency  = res.frequency;
	assign no_signal  = res.no_signal;
	assign cap_value  = res.cap_value;
	assign unit_is_uf = res.unit_is_uf;

	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		gate_valid |-> !q_full)
		else $error("gate closed while gate queue full");

	a_no_signal_zero_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_signal) |-> (cap_value == 32'd0 && !unit_is_uf && frequency == 32'd0))
		else $error("no-signal result carries a capacitance");

	a_nf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !unit_is_uf) |-> (cap_value < 32'd1000))
		else $error("nanofarad result not below 1000");

	a_uf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && unit_is_uf) |-> (cap_value >= 32'd1 && cap_value <= 32'd4294967))
		else $error("microfarad result out of range");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gated_capacitance_meter_unit: gates of edge counts in, readings out.
// Predicts each reading from its own copy of the counters and registers; depends on gcm_pkg.
module tb_top;

	localparam int CYCLE_LIMIT   = 400_000;
	localparam int SETTLE_CYCLES = 80;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            push;
	logic                            full;
	logic                            signal_edge;
	logic                            base_tick;
	logic                            empty;
	logic                            pop;
	logic [31:0]                     frequency;
	logic                            no_signal;
	logic [31:0]                     cap_value;
	logic                            unit_is_uf;
	logic                            wr_en;
	logic [gcm_pkg::REG_IDX_W-1:0]   wr_index;
	logic [gcm_pkg::WDATA_W-1:0]     wr_data;

	// predicted block state and registers
	logic [15:0]                     gate_len;
	logic [19:0]                     res_ohms;
	logic [31:0]                     numerator;
	logic [gcm_pkg::COUNT_WIDTH-1:0] edge_total;
	logic [15:0]                     tick_total;

	gcm_pkg::res_t          expected_readings[$];
	int                     mismatches = 0;
	int                     cycle_count = 0;
	int                     src_gap_max = 8;
	int                     sink_gap_max = 8;
	int                     sink_hold = 0;

	gated_capacitance_meter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.signal_edge(signal_edge),
		.base_tick  (base_tick),
		.empty      (empty),
		.pop        (pop),
		.frequency  (frequency),
		.no_signal  (no_signal),
		.cap_value  (cap_value),
		.unit_is_uf (unit_is_uf),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d readings outstanding", $time, expected_readings.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic predict_reading(input logic has_edge, input logic has_tick);
		logic [15:0]   next_ticks;
		logic [31:0]   count;
		logic [63:0]   denom;
		logic [31:0]   nf;
		gcm_pkg::res_t r;
		if (has_edge && edge_total != '1)
			edge_total++;
		if (!has_tick)
			return;
		next_ticks = tick_total + 16'd1;
		if (next_ticks < gate_len && next_ticks != 16'd0) begin
			tick_total = next_ticks;
			return;
		end
		count = edge_total;
		edge_total = '0;
		tick_total = '0;
		r.frequency = count;
		r.no_signal = (count == 32'd0);
		r.cap_value = 32'd0;
		r.unit_is_uf = 1'b0;
		if (count != 32'd0) begin
			denom = 64'(res_ohms) * 64'(count);
			if (denom == 64'd0)
				nf = '1;
			else
				nf = 32'(64'(numerator) / denom);
			if (nf >= gcm_pkg::NF_PER_UF) begin
				r.cap_value = nf / gcm_pkg::NF_PER_UF;
				r.unit_is_uf = 1'b1;
			end else begin
				r.cap_value = nf;
			end
		end
		expected_readings.push_back(r);
	endtask

	task automatic send_sample(input logic has_edge, input logic has_tick);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		signal_edge <= has_edge;
		base_tick <= has_tick;
		do @(posedge clk); while (full);
		predict_reading(has_edge, has_tick);
	endtask

	// hold input until every reading is in, then let the divider settle
	task automatic drain_readings();
		push <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gcm_pkg::REG_IDX_W-1:0] idx,
			input logic [gcm_pkg::WDATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			gcm_pkg::REG_GATE_TICKS:     gate_len = data[15:0];
			gcm_pkg::REG_RESISTANCE_SUM: res_ohms = data[19:0];
			gcm_pkg::REG_CAP_NUMERATOR:  numerator = data;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] g, input logic [19:0] r, input logic [31:0] n);
		drain_readings();
		write_reg(gcm_pkg::REG_GATE_TICKS, {16'($urandom), g});
		write_reg(gcm_pkg::REG_RESISTANCE_SUM, {12'($urandom), r});
		write_reg(gcm_pkg::REG_CAP_NUMERATOR, n);
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// result side: random stalls, optional long hold-off, check every transaction
	initial begin
		gcm_pkg::res_t got;
		gcm_pkg::res_t want;
		int            gap;
		pop <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				pop <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			gap = $urandom_range(0, sink_gap_max);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got.frequency = frequency;
			got.no_signal = no_signal;
			got.cap_value = cap_value;
			got.unit_is_uf = unit_is_uf;
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected reading: frequency %0d cap_value %0d", $time,
					got.frequency, got.cap_value);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				compare_field("frequency", want.frequency, got.frequency);
				compare_field("no_signal", 32'(want.no_signal), 32'(got.no_signal));
				compare_field("cap_value", want.cap_value, got.cap_value);
				compare_field("unit_is_uf", 32'(want.unit_is_uf), 32'(got.unit_is_uf));
			end
		end
	end

	// one full gate on the reset register values
	task automatic test_reset_values();
		src_gap_max = 0;
		repeat (1000) send_sample(1'b1, 1'b1);
		drain_readings();
		src_gap_max = 8;
	endtask

	task automatic test_directed();
		apply_settings(16'd1, 20'd4800, 32'd1440000000);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b1);
		send_sample(1'b1, 1'b0);
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b1);
		apply_settings(16'd0, 20'd4800, 32'd1440000000);
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b0);
		apply_settings(16'd0, 20'd0, 32'd1440000000);
		send_sample(1'b1, 1'b1);
		apply_settings(16'd1, 20'hFFFFF, 32'hFFFF_FFFF);
		send_sample(1'b1, 1'b1);
		repeat (4) send_sample(1'b1, 1'b0);
		send_sample(1'b1, 1'b1);
		apply_settings(16'd1, 20'd1, 32'd0);
		send_sample(1'b1, 1'b1);
		apply_settings(16'd1, 20'd1, 32'd1000);
		send_sample(1'b1, 1'b1);
		apply_settings(16'd1, 20'd1, 32'd999);
		send_sample(1'b1, 1'b1);
		apply_settings(16'd3, 20'd7, 32'd123456);
		send_sample(1'b1, 1'b0);
		send_sample(1'b0, 1'b1);
		send_sample(1'b1, 1'b1);
		send_sample(1'b0, 1'b0);
		send_sample(1'b0, 1'b1);
		drain_readings();
	endtask

	// long gate cut short by a smaller gate length in mid-gate
	task automatic test_long_gate();
		apply_settings(16'hFFFF, 20'd1, 32'hFFFF_FFFF);
		src_gap_max = 0;
		repeat (100) send_sample(1'($urandom), 1'b1);
		apply_settings(16'd5, 20'd1, 32'hFFFF_FFFF);
		send_sample(1'b1, 1'b1);
		drain_readings();
		src_gap_max = 8;
	endtask

	// hold off the result side so closed gates pile up and full asserts
	task automatic test_backpressure();
		apply_settings(16'd1, 20'd4800, 32'd1440000000);
		src_gap_max = 0;
		sink_hold = 400;
		repeat (100) send_sample(1'($urandom), 1'b1);
		drain_readings();
		src_gap_max = 8;
	endtask

	task automatic test_random_traffic();
		logic [15:0] g;
		logic [19:0] r;
		logic [31:0] n;
		int          edge_pct;
		int          tick_pct;
		for (int phase = 0; phase < 12; phase++) begin
			case ($urandom_range(0, 4))
				0: g = 16'd0;
				1: g = 16'd1;
				2, 3: g = 16'($urandom_range(2, 6));
				default: g = 16'($urandom_range(7, 40));
			endcase
			case ($urandom_range(0, 5))
				0: r = 20'd0;
				1: r = 20'd1;
				2: r = 20'hFFFFF;
				3, 4: r = 20'($urandom_range(1, 10000));
				default: r = 20'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: n = 32'd0;
				1: n = 32'hFFFF_FFFF;
				2: n = 32'd1440000000;
				3: n = 32'($urandom_range(1, 2000));
				default: n = $urandom;
			endcase
			case ($urandom_range(0, 4))
				0: edge_pct = 0;
				1: edge_pct = 100;
				default: edge_pct = $urandom_range(5, 95);
			endcase
			tick_pct = $urandom_range(30, 100);
			apply_settings(g, r, n);
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			repeat (30)
				send_sample($urandom_range(0, 99) < edge_pct, $urandom_range(0, 99) < tick_pct);
		end
		src_gap_max = 8;
		sink_gap_max = 8;
	endtask

	initial begin
		gate_len = 16'd1000;
		res_ohms = 20'd4800;
		numerator = 32'd1440000000;
		edge_total = '0;
		tick_total = '0;
		arst_n <= 1'b0;
		push <= 1'b0;
		signal_edge <= 1'b0;
		base_tick <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= gcm_pkg::REG_GATE_TICKS;
		wr_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_long_gate();
		test_backpressure();
		test_random_traffic();
		drain_readings();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
